[hdl/sms_pkg.sv]
// Shared types, sizes and helpers for the sparse matrix tuple store.
// Depends on nothing; every other file imports it.
`default_nettype none

package sms_pkg;

  localparam int CAPACITY   = 256;
  localparam int INDEX_BITS = 16;
  localparam int KEY_W      = 2 * INDEX_BITS;
  localparam int VALUE_W    = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 8;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int RED_FANIN  = 8;

  function automatic int red_levels(int n);
    int lv;
    int span;
    lv   = 0;
    span = 1;
    while (span < n) begin
      span = span * RED_FANIN;
      lv++;
    end
    return (lv < 1) ? 1 : lv;
  endfunction

  localparam int RED_LEVELS = red_levels(CAPACITY);
  localparam int LVL_W      = (RED_LEVELS > 1) ? $clog2(RED_LEVELS) : 1;

  // number of nodes on a level of the hit tree; level 0 is the cells
  function automatic int lvl_size(int l);
    int s;
    s = CAPACITY;
    for (int k = 0; k < l; k++) begin
      s = (s + RED_FANIN - 1) / RED_FANIN;
    end
    return s;
  endfunction

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_GET  = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_ACC  = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [63:0] value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [63:0] value_out;
    logic [15:0]        row_out;
    logic [15:0]        col_out;
    logic [8:0]         entry_count;
    status_t            status;
  } rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_COMPARE = 3'd1,
    CELL_UPDATE  = 3'd2,
    CELL_INSERT  = 3'd3,
    CELL_DELETE  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic   found;
    entry_t entry;
  } hit_t;

  localparam int HIT_W = $bits(hit_t);

  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               read_at;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_GATHER,
    S_APPLY
  } state_t;

  function automatic logic [KEY_W-1:0] make_key(logic [15:0] row, logic [15:0] col);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < INDEX_BITS && b < 16; b++) begin
      k[b]              = col[b];
      k[INDEX_BITS + b] = row[b];
    end
    return k;
  endfunction

  function automatic logic [15:0] key_row(logic [KEY_W-1:0] k);
    logic [15:0] r;
    r = '0;
    for (int b = 0; b < INDEX_BITS && b < 16; b++) begin
      r[b] = k[INDEX_BITS + b];
    end
    return r;
  endfunction

  function automatic logic [15:0] key_col(logic [KEY_W-1:0] k);
    logic [15:0] c;
    c = '0;
    for (int b = 0; b < INDEX_BITS && b < 16; b++) begin
      c[b] = k[b];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/sms_cell.sv]
// One slot of the sorted entry chain: holds a key and value, compares, shifts.
// Depends on sms_pkg.
`default_nettype none

module sms_cell import sms_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic             left_less,
  input  entry_t           left_entry,
  input  entry_t           right_entry,
  output logic             less,
  output entry_t           entry,
  output hit_t             hit_data
);

  logic hit;
  logic valid;
  logic pos_match;

  always_comb begin
    valid     = idx < ctl.count;
    pos_match = CMP_W'(ctl.pos) == CMP_W'(idx);
    hit_data  = hit ? hit_t'{found: 1'b1, entry: entry} : '0;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_COMPARE: begin
        less <= valid && (entry.key < ctl.key);
        hit  <= ctl.read_at ? (valid && pos_match) : (valid && (entry.key == ctl.key));
      end
      CELL_UPDATE: begin
        if (hit) entry.value <= ctl.value;
      end
      CELL_INSERT: begin
        // take the new entry at the insert point, the left neighbor beyond it
        if (!less) entry <= left_less ? entry_t'{key: ctl.key, value: ctl.value} : left_entry;
      end
      CELL_DELETE: begin
        if (!less) entry <= right_entry;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/sms_or_tree.sv]
// Registered OR tree that gathers the one hit cell's entry from the chain.
// Depends on sms_pkg.
`default_nettype none

module sms_or_tree import sms_pkg::*; (
  input  logic clk,
  input  hit_t leaves [CAPACITY],
  output hit_t root
);

  logic [HIT_W-1:0] node      [RED_LEVELS][CAPACITY];
  logic [HIT_W-1:0] node_next [RED_LEVELS][CAPACITY];

  always_comb begin
    for (int l = 0; l < RED_LEVELS; l++) begin
      for (int n = 0; n < CAPACITY; n++) begin
        node_next[l][n] = '0;
        if (n < lvl_size(l + 1)) begin
          for (int j = 0; j < RED_FANIN; j++) begin
            if (n * RED_FANIN + j < lvl_size(l)) begin
              if (l == 0) node_next[l][n] = node_next[l][n] | leaves[n * RED_FANIN + j];
              else        node_next[l][n] = node_next[l][n] | node[l - 1][n * RED_FANIN + j];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
  end

  assign root = hit_t'(node[RED_LEVELS - 1][0]);

endmodule

`default_nettype wire

[hdl/sparse_matrix_tuple_store.sv]
// Sparse matrix tuple store: keeps up to CAPACITY nonzero (row, col, value)
// entries sorted row-major in a chain of cells and serves get, set,
// accumulate and read-at requests, one response beat per request beat.
// Each request runs through the chain in order: the idle state takes the beat,
// the compare state has every cell compare its key against the request (for
// read-at, its index against the position), the gather state passes the hit
// through the RED_LEVELS registered levels of the OR tree that brings the
// matching cell's entry to the controller, and the apply state has the chain
// insert, update or delete by shifting one slot toward its neighbor. The next
// request is taken only after apply, so one request is in the chain at a time;
// a stalled response holds the apply state until the response register frees.
// Depends on sms_pkg, sms_cell and sms_or_tree.
`default_nettype none

module sparse_matrix_tuple_store import sms_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t           state;
  state_t           state_next;
  logic [LVL_W-1:0] gather_cnt;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  req_t             req_hold;
  logic [KEY_W-1:0] req_key;

  cell_ctl_t        ctl;
  cell_op_t         apply_op;
  rsp_t             rsp_next;
  logic             fire;

  entry_t           entries [CAPACITY];
  logic             less    [CAPACITY];
  hit_t             hits    [CAPACITY];
  hit_t             root;

  logic [VALUE_W-1:0] old_val;
  logic [VALUE_W-1:0] sum;
  logic [VALUE_W-1:0] store_val;
  logic               sat;

  // ---------------------------------------------------------------------
  // Cell chain: each cell sees its left neighbor for insert shifts and its
  // right neighbor for delete shifts.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_less;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_less  = 1'b1;
      assign left_entry = '0;
    end else begin : g_inner
      assign left_less  = less[i - 1];
      assign left_entry = entries[i - 1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entries[i + 1];
    end

    sms_cell u_cell (
      .clk         (clk),
      .idx         (CNT_W'(i)),
      .ctl         (ctl),
      .left_less   (left_less),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .less        (less[i]),
      .entry       (entries[i]),
      .hit_data    (hits[i])
    );
  end

  sms_or_tree u_tree (
    .clk    (clk),
    .leaves (hits),
    .root   (root)
  );

  // ---------------------------------------------------------------------
  // Apply datapath: work out the stored value, the chain action, the new
  // count and the response beat from the gathered hit.
  // ---------------------------------------------------------------------
  always_comb begin
    old_val   = root.found ? root.entry.value : '0;
    sum       = old_val + req_hold.value;
    // same signs in, different sign out: clamp toward the operands' sign
    sat       = (req_hold.func == FUNC_ACC) && (old_val[VALUE_W-1] == req_hold.value[VALUE_W-1])
                && (sum[VALUE_W-1] != old_val[VALUE_W-1]);
    store_val = req_hold.value;
    if (req_hold.func == FUNC_ACC) begin
      store_val = sat ? (old_val[VALUE_W-1] ? VAL_MIN : VAL_MAX) : sum;
    end

    apply_op             = CELL_HOLD;
    count_next           = count;
    rsp_next.value_out   = '0;
    rsp_next.row_out     = req_hold.row;
    rsp_next.col_out     = req_hold.col;
    rsp_next.status      = ST_OK;

    case (req_hold.func)
      FUNC_GET: begin
        rsp_next.value_out = old_val;
      end
      FUNC_READ: begin
        if (root.found) begin
          rsp_next.value_out = root.entry.value;
          rsp_next.row_out   = key_row(root.entry.key);
          rsp_next.col_out   = key_col(root.entry.key);
        end else begin
          rsp_next.status = ST_RANGE;
        end
      end
      default: begin
        if (store_val == '0) begin
          // zero result: drop the entry if it is there
          if (root.found) begin
            apply_op   = CELL_DELETE;
            count_next = count - CNT_W'(1);
          end
        end else if (root.found) begin
          apply_op           = CELL_UPDATE;
          rsp_next.value_out = store_val;
        end else if (count == CNT_W'(CAPACITY)) begin
          rsp_next.status = ST_FULL;
        end else begin
          apply_op           = CELL_INSERT;
          count_next         = count + CNT_W'(1);
          rsp_next.value_out = store_val;
        end
        if (rsp_next.status == ST_OK && sat) rsp_next.status = ST_SAT;
      end
    endcase

    rsp_next.entry_count = 9'(count_next);
  end

  assign fire = (state == S_APPLY) && (!rsp_valid || rsp_ready);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (req_valid) state_next = S_COMPARE;
      S_COMPARE: state_next = S_GATHER;
      S_GATHER:  if (gather_cnt == LVL_W'(RED_LEVELS - 1)) state_next = S_APPLY;
      S_APPLY:   if (fire) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = (state == S_IDLE);
    ctl.key     = req_key;
    ctl.value   = store_val;
    ctl.read_at = (req_hold.func == FUNC_READ);
    ctl.pos     = req_hold.position;
    ctl.count   = count;
    case (state)
      S_COMPARE: ctl.op = CELL_COMPARE;
      S_APPLY:   ctl.op = fire ? apply_op : CELL_HOLD;
      default:   ctl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gather_cnt <= '0;
      count      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_COMPARE)     gather_cnt <= '0;
      else if (state == S_GATHER) gather_cnt <= gather_cnt + LVL_W'(1);
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload: hold the request beat and the response beat.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_hold <= req;
      req_key  <= make_key(req.row, req.col);
    end
    if (fire) rsp <= rsp_next;
  end

endmodule

`default_nettype wire

[hdl/sms_checker.sv]
// Port-level checks for sparse_matrix_tuple_store, bound onto the top level.
// Depends on sms_pkg.
`default_nettype none

module sms_checker import sms_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // one request in flight: a taken beat closes the request side next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.entry_count) <= CAPACITY) || (CAPACITY > 511))
    else $error("entry count above capacity");

  a_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_RANGE || rsp.status == ST_FULL)) |-> rsp.value_out == '0)
    else $error("nonzero value on a dropped or out-of-range request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response beat changed while stalled");

endmodule

bind sparse_matrix_tuple_store sms_checker u_sms_checker (.*);

`default_nettype wire

[verif/sparse_matrix_tuple_store_tb.sv]
// Testbench for sparse_matrix_tuple_store: directed and random get/set/accumulate/read-at
// beats, checked against a scoreboard that keeps its own sorted copy of the matrix.
// Depends on sms_pkg and the sparse_matrix_tuple_store RTL.
`timescale 1ns / 100ps

module sparse_matrix_tuple_store_tb;
  import sms_pkg::*;

  localparam int POOL_N         = 320;  // more keys than the store can hold
  localparam int HOLD_AT        = 150;  // response count at which the long hold starts
  localparam int LONG_HOLD      = 300;  // cycles of the long receiver hold
  localparam int WATCHDOG_LIMIT = 1000; // cycles with no beat on either channel
  localparam int DRAIN_CYCLES   = 20;   // settle time after the last response

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  sparse_matrix_tuple_store dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Request beats waiting to be driven, and responses predicted for accepted beats.
  req_t pending_req_q[$];
  rsp_t expected_rsp_q[$];

  // Scoreboard copy of the matrix: keys {row, col} sorted ascending, one value per key.
  logic [31:0] mat_keys [CAPACITY];
  logic [63:0] mat_vals [CAPACITY];
  int          mat_count = 0;

  logic [31:0] key_pool [POOL_N];

  int  mismatch_count = 0;
  int  rsp_seen = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  quiet_cycles = 0;
  bit  tx_steady = 1'b0;  // sender offers back-to-back beats
  bit  rx_steady = 1'b0;  // receiver does not stall, apart from the long hold

  // First slot whose key is not below k.
  function automatic int lower_slot(logic [31:0] k);
    int p;
    p = 0;
    while (p < mat_count && mat_keys[p] < k) p++;
    return p;
  endfunction

  function automatic logic [63:0] lookup_value(logic [31:0] k);
    int p;
    p = lower_slot(k);
    if (p < mat_count && mat_keys[p] == k) return mat_vals[p];
    return '0;
  endfunction

  // Write v at key k: delete on zero, update in place, else insert unless full.
  task automatic store_entry(input logic [31:0] k, input logic [63:0] v,
                             output logic [63:0] held, output status_t st);
    int  p;
    bit  hit;
    p    = lower_slot(k);
    hit  = (p < mat_count) && (mat_keys[p] == k);
    held = '0;
    st   = ST_OK;
    if (v == '0) begin
      if (hit) begin
        for (int i = p; i + 1 < mat_count; i++) begin
          mat_keys[i] = mat_keys[i + 1];
          mat_vals[i] = mat_vals[i + 1];
        end
        mat_count--;
      end
    end else if (hit) begin
      mat_vals[p] = v;
      held        = v;
    end else if (mat_count >= CAPACITY) begin
      st = ST_FULL;
    end else begin
      for (int i = mat_count; i > p; i--) begin
        mat_keys[i] = mat_keys[i - 1];
        mat_vals[i] = mat_vals[i - 1];
      end
      mat_keys[p] = k;
      mat_vals[p] = v;
      mat_count++;
      held = v;
    end
  endtask

  // Advance the matrix copy by one request and return the response it must produce.
  task automatic apply_matrix_request(input req_t r, output rsp_t e);
    logic [31:0] k;
    logic [63:0] old_val;
    logic [63:0] sum;
    logic [63:0] held;
    logic        sat;
    status_t     st;
    k           = {r.row, r.col};
    e.value_out = '0;
    e.row_out   = r.row;
    e.col_out   = r.col;
    e.status    = ST_OK;
    case (r.func)
      FUNC_GET: begin
        e.value_out = lookup_value(k);
      end
      FUNC_SET: begin
        store_entry(k, r.value, held, st);
        e.value_out = held;
        e.status    = st;
      end
      FUNC_ACC: begin
        old_val = lookup_value(k);
        sum     = old_val + r.value;
        // overflow only when both addends share a sign and the sum does not
        sat     = (old_val[63] == r.value[63]) && (sum[63] != old_val[63]);
        if (sat) sum = old_val[63] ? VAL_MIN : VAL_MAX;
        store_entry(k, sum, held, st);
        e.value_out = held;
        e.status    = (st == ST_OK && sat) ? ST_SAT : st;
      end
      default: begin
        if (int'(r.position) < mat_count) begin
          e.value_out = mat_vals[r.position];
          e.row_out   = mat_keys[r.position][31:16];
          e.col_out   = mat_keys[r.position][15:0];
        end else begin
          e.status = ST_RANGE;
        end
      end
    endcase
    e.entry_count = 9'(mat_count);
  endtask

  function automatic req_t req_of(func_t f, logic [15:0] r, logic [15:0] c,
                                  logic [63:0] v, logic [7:0] p);
    req_t q;
    q.func     = f;
    q.row      = r;
    q.col      = c;
    q.value    = v;
    q.position = p;
    return q;
  endfunction

  // Mix of full-range, small (so sums cancel to zero), zero and near-limit values.
  function automatic logic [63:0] draw_value();
    int pick;
    int sv;
    pick = $urandom_range(0, 99);
    sv   = $urandom_range(1, 3);
    if ($urandom_range(0, 1)) sv = -sv;
    if (pick < 40) return {$urandom, $urandom};
    if (pick < 60) return {{32{sv[31]}}, sv};
    if (pick < 72) return '0;
    if (pick < 86) return VAL_MAX - 64'($urandom_range(0, 3));
    return VAL_MIN + 64'($urandom_range(0, 3));
  endfunction

  // One random request; del_pct raises the share of set-to-zero deletes.
  function automatic req_t random_request(int del_pct);
    int          pick;
    logic [31:0] k;
    logic [63:0] v;
    k    = ($urandom_range(0, 19) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_N - 1)];
    v    = draw_value();
    pick = $urandom_range(0, 99);
    if (pick < del_pct) return req_of(FUNC_SET, k[31:16], k[15:0], '0, 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 20) return req_of(FUNC_GET, k[31:16], k[15:0], v, 8'($urandom));
    if (pick < 50) return req_of(FUNC_SET, k[31:16], k[15:0], v, 8'($urandom));
    if (pick < 80) return req_of(FUNC_ACC, k[31:16], k[15:0], v, 8'($urandom));
    return req_of(FUNC_READ, k[31:16], k[15:0], v, 8'($urandom_range(0, 255)));
  endfunction

  // Hold until every queued beat is accepted and every predicted response has come.
  task automatic wait_until_drained();
    while (pending_req_q.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Driver: predict on each accepted beat, then offer the next one after its gap.
  // Valid only changes when no beat is waiting, so a stalled beat holds steady.
  always @(posedge clk) begin : drive_requests
    rsp_t e;
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (req_valid && req_ready) begin
        apply_matrix_request(req, e);
        expected_rsp_q.push_back(e);
      end
      if (!req_valid || req_ready) begin
        if (tx_gap > 0) begin
          tx_gap    <= tx_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          req       <= pending_req_q.pop_front();
          req_valid <= 1'b1;
          tx_gap    <= tx_steady ? 0 : $urandom_range(0, 16);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: check each response beat against the oldest prediction, then draw
  // the next stall. One response count triggers the long hold that backs up the
  // store until it drops req_ready.
  always @(posedge clk) begin : check_responses
    rsp_t want;
    int   stall;
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_stall  <= 0;
    end else if (rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: response beat with nothing expected, actual value %h status %0d",
                 $time, rsp.value_out, rsp.status);
        mismatch_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("value_out", want.value_out, rsp.value_out);
        check_field("row_out", 64'(want.row_out), 64'(rsp.row_out));
        check_field("col_out", 64'(want.col_out), 64'(rsp.col_out));
        check_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
        check_field("status", 64'(want.status), 64'(rsp.status));
      end
      rsp_seen <= rsp_seen + 1;
      if (rsp_seen + 1 == HOLD_AT) stall = LONG_HOLD;
      else stall = rx_steady ? 0 : $urandom_range(0, 16);
      rx_stall  <= stall;
      rsp_ready <= (stall == 0);
    end else if (rx_stall > 0) begin
      rx_stall  <= rx_stall - 1;
      rsp_ready <= (rx_stall == 1);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog: drop the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("sparse_matrix_tuple_store verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    req_t r;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-store lookups, corner keys, sorted read-back, both
    // saturation directions, deletes by set and by cancelling accumulate,
    // set of zero on an absent key, accumulate into an absent key.
    pending_req_q.push_back(req_of(FUNC_GET,  16'h0000, 16'h0000, 64'd5, 8'd0));
    pending_req_q.push_back(req_of(FUNC_READ, 16'h0000, 16'h0000, '0, 8'd0));
    pending_req_q.push_back(req_of(FUNC_SET,  16'h0000, 16'h0000, 64'd1, 8'd0));
    pending_req_q.push_back(req_of(FUNC_SET,  16'hffff, 16'hffff, VAL_MIN, 8'hff));
    pending_req_q.push_back(req_of(FUNC_SET,  16'h0000, 16'hffff, VAL_MAX, 8'd0));
    pending_req_q.push_back(req_of(FUNC_SET,  16'hffff, 16'h0000, '1, 8'd0));
    pending_req_q.push_back(req_of(FUNC_GET,  16'h0000, 16'hffff, '0, 8'd0));
    for (int p = 0; p < 5; p++)
      pending_req_q.push_back(req_of(FUNC_READ, 16'h1234, 16'h5678, '0, 8'(p)));
    pending_req_q.push_back(req_of(FUNC_ACC,  16'h0000, 16'hffff, 64'd1, 8'd0));
    pending_req_q.push_back(req_of(FUNC_ACC,  16'hffff, 16'hffff, '1, 8'd0));
    pending_req_q.push_back(req_of(FUNC_ACC,  16'h0000, 16'h0000, '1, 8'd0));
    pending_req_q.push_back(req_of(FUNC_SET,  16'hffff, 16'h0000, '0, 8'd0));
    pending_req_q.push_back(req_of(FUNC_SET,  16'h1234, 16'h5678, '0, 8'd0));
    pending_req_q.push_back(req_of(FUNC_ACC,  16'h00ff, 16'hff00, 64'd5, 8'd0));
    pending_req_q.push_back(req_of(FUNC_SET,  16'h00ff, 16'hff00, 64'd7, 8'd0));
    pending_req_q.push_back(req_of(FUNC_ACC,  16'h0000, 16'hffff, VAL_MIN, 8'd0));
    pending_req_q.push_back(req_of(FUNC_GET,  16'hffff, 16'hffff, '0, 8'd0));
    pending_req_q.push_back(req_of(FUNC_READ, 16'hffff, 16'hffff, '0, 8'hff));
    wait_until_drained();

    // Fill: insert every pool key, far past capacity, so later inserts are
    // dropped as full. Run back-to-back; the long hold lands in this stretch.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < POOL_N; i++) begin
      r = req_of(FUNC_SET, key_pool[i][31:16], key_pool[i][15:0], draw_value(), 8'd0);
      if (r.value == '0) r.value = {$urandom, $urandom} | 64'd1;
      pending_req_q.push_back(r);
      if ($urandom_range(0, 3) == 0) pending_req_q.push_back(random_request(0));
    end
    while (pending_req_q.size() != 0) @(posedge clk);

    // Mixed traffic; one delete-heavy stretch drains the store so inserts
    // succeed again, and each side gets a stretch without idling.
    for (int s = 0; s < 6; s++) begin
      tx_steady = (s == 2);
      rx_steady = (s == 4);
      for (int i = 0; i < 240; i++) pending_req_q.push_back(random_request(s == 1 ? 45 : 5));
      while (pending_req_q.size() != 0) @(posedge clk);
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("sparse_matrix_tuple_store verification clean");
    end else begin
      $display("sparse_matrix_tuple_store verification failed");
    end
    $finish;
  end

endmodule
